@@ sv/wpf_pkg.sv @@
// shared constants, state encoding and control structs for the palindrome word finder
package wpf_pkg;

   localparam int MAX_WORD_DEF = 32;
   localparam int NUM_W        = 16;
   localparam int LEN_W        = 6;
   localparam logic [NUM_W-1:0] CNT_MAX = '1;

   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_FINISH
   } wpf_state_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic check;
      logic finish;
   } wpf_cmd_type;

   typedef struct packed {
      logic closes_word;
      logic pairs_done;
      logic slot_free;
   } wpf_sts_type;

endpackage

@@ sv/wpf_channels.sv @@
// valid/ready channel interfaces for text bytes and word results
interface wpf_req_if
   import wpf_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface wpf_rsp_if
   import wpf_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] word_number;
   logic [LEN_W-1:0] word_length;
   logic             is_palindrome;
   logic             word_too_long;
   logic             best_found;
   logic [NUM_W-1:0] best_number;
   logic [LEN_W-1:0] best_length;
   logic [NUM_W-1:0] palindrome_total;

   modport source (output valid, output word_number, output word_length, output is_palindrome,
                   output word_too_long, output best_found, output best_number,
                   output best_length, output palindrome_total, input ready);
   modport sink   (input valid, input word_number, input word_length, input is_palindrome,
                   input word_too_long, input best_found, input best_number,
                   input best_length, input palindrome_total, output ready);
endinterface

@@ sv/wpf_ram.sv @@
// generic ram, one write port and two registered read ports
module wpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ sv/wpf_ctrl.sv @@
// controller state machine: byte intake, mirror check sequencing, result hand-off
module wpf_ctrl
   import wpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  wpf_sts_type sts,
   output wpf_cmd_type cmd
);

   wpf_state_type state_ff;
   wpf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.closes_word) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.pairs_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = sts.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/wpf_datapath.sv @@
// datapath: word buffer, pairwise mirror compare, running counters and result register
module wpf_datapath
   import wpf_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  wpf_cmd_type      cmd,
   output wpf_sts_type      sts,
   input  logic [7:0]       text_byte,
   input  logic             last_byte,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [NUM_W-1:0] word_number,
   output logic [LEN_W-1:0] word_length,
   output logic             is_palindrome,
   output logic             word_too_long,
   output logic             best_found,
   output logic [NUM_W-1:0] best_number,
   output logic [LEN_W-1:0] best_length,
   output logic [NUM_W-1:0] palindrome_total
);

   localparam int AddrW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int FillW = $clog2(MAX_WORD + 1);
   localparam logic [FillW-1:0] FillMax = FillW'(MAX_WORD);

   logic [FillW-1:0] fill_ff, fill_in;
   logic             over_ff, over_in;
   logic             last_ff, last_in;
   logic [NUM_W-1:0] wcnt_ff, wcnt_in;
   logic [NUM_W-1:0] pcnt_ff, pcnt_in;
   logic [FillW-1:0] blen_ff, blen_in;
   logic [NUM_W-1:0] bidx_ff, bidx_in;
   logic             bvld_ff, bvld_in;
   logic [FillW-1:0] lo_ff, lo_in;
   logic [FillW-1:0] hi_ff, hi_in;
   logic             rdp_ff, rdp_in;
   logic             mism_ff, mism_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [NUM_W-1:0] out_num_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic             out_pal_ff;
   logic             out_long_ff;
   logic             out_bvld_ff;
   logic [NUM_W-1:0] out_bidx_ff;
   logic [LEN_W-1:0] out_blen_ff;
   logic [NUM_W-1:0] out_pcnt_ff;

   logic             is_sep;
   logic             has_room;
   logic             pair_left;
   logic             issue;
   logic             wr_en;
   logic [7:0]       rd_lo;
   logic [7:0]       rd_hi;
   logic             pal;
   logic             better;
   logic [NUM_W-1:0] pcnt_new;
   logic [FillW-1:0] blen_new;
   logic [NUM_W-1:0] bidx_new;
   logic             bvld_new;

   assign is_sep    = text_byte inside {CHAR_COMMA, CHAR_SPACE, CHAR_PERIOD};
   assign has_room  = fill_ff < FillMax;
   assign pair_left = lo_ff < hi_ff;
   assign issue     = cmd.check && pair_left;
   assign wr_en     = cmd.accept && !is_sep && has_room;

   wpf_ram #(
      .WIDTH(8),
      .DEPTH(MAX_WORD)
   ) u_word_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (fill_ff[AddrW-1:0]),
      .wr_data  (text_byte),
      .rd_addr_a(lo_ff[AddrW-1:0]),
      .rd_addr_b(hi_ff[AddrW-1:0]),
      .rd_data_a(rd_lo),
      .rd_data_b(rd_hi)
   );

   // word close: new record values as seen in the result
   always_comb begin
      pal      = !over_ff && !mism_ff;
      better   = pal && (fill_ff > blen_ff);
      pcnt_new = (pal && pcnt_ff != CNT_MAX) ? pcnt_ff + NUM_W'(1) : pcnt_ff;
      blen_new = better ? fill_ff : blen_ff;
      bidx_new = better ? wcnt_ff : bidx_ff;
      bvld_new = better ? 1'b1 : bvld_ff;
   end

   always_comb begin
      fill_in = fill_ff;
      over_in = over_ff;
      last_in = last_ff;
      wcnt_in = wcnt_ff;
      pcnt_in = pcnt_ff;
      blen_in = blen_ff;
      bidx_in = bidx_ff;
      bvld_in = bvld_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      rdp_in  = rdp_ff;
      mism_in = mism_ff;

      if (cmd.accept) begin
         last_in = last_byte;
         if (!is_sep) begin
            if (has_room) begin
               fill_in = fill_ff + FillW'(1);
            end else begin
               over_in = 1'b1;
            end
         end
      end

      if (cmd.setup) begin
         lo_in   = '0;
         hi_in   = (fill_ff == '0) ? '0 : fill_ff - FillW'(1);
         rdp_in  = 1'b0;
         mism_in = 1'b0;
      end

      // read of a pair goes out while the previous pair is compared
      if (cmd.check) begin
         rdp_in = issue;
         if (issue) begin
            lo_in = lo_ff + FillW'(1);
            hi_in = hi_ff - FillW'(1);
         end
         if (rdp_ff && (rd_lo != rd_hi)) begin
            mism_in = 1'b1;
         end
      end

      if (cmd.finish) begin
         fill_in = '0;
         over_in = 1'b0;
         if (last_ff) begin
            wcnt_in = '0;
            pcnt_in = '0;
            blen_in = '0;
            bidx_in = '0;
            bvld_in = 1'b0;
         end else begin
            wcnt_in = (wcnt_ff != CNT_MAX) ? wcnt_ff + NUM_W'(1) : wcnt_ff;
            pcnt_in = pcnt_new;
            blen_in = blen_new;
            bidx_in = bidx_new;
            bvld_in = bvld_new;
         end
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         over_ff      <= 1'b0;
         last_ff      <= 1'b0;
         wcnt_ff      <= '0;
         pcnt_ff      <= '0;
         blen_ff      <= '0;
         bidx_ff      <= '0;
         bvld_ff      <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rdp_ff       <= 1'b0;
         mism_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         over_ff      <= over_in;
         last_ff      <= last_in;
         wcnt_ff      <= wcnt_in;
         pcnt_ff      <= pcnt_in;
         blen_ff      <= blen_in;
         bidx_ff      <= bidx_in;
         bvld_ff      <= bvld_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rdp_ff       <= rdp_in;
         mism_ff      <= mism_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_num_ff  <= wcnt_ff;
         out_len_ff  <= LEN_W'(fill_ff);
         out_pal_ff  <= pal;
         out_long_ff <= over_ff;
         out_bvld_ff <= bvld_new;
         out_bidx_ff <= bidx_new;
         out_blen_ff <= LEN_W'(blen_new);
         out_pcnt_ff <= pcnt_new;
      end
   end

   assign sts.closes_word = is_sep || last_byte;
   assign sts.pairs_done  = !pair_left && !rdp_ff;
   assign sts.slot_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign word_number      = out_num_ff;
   assign word_length      = out_len_ff;
   assign is_palindrome    = out_pal_ff;
   assign word_too_long    = out_long_ff;
   assign best_found       = out_bvld_ff;
   assign best_number      = out_bidx_ff;
   assign best_length      = out_blen_ff;
   assign palindrome_total = out_pcnt_ff;

endmodule

@@ sv/word_palindrome_finder.sv @@
// top level of the palindrome word finder: controller, datapath and channel hookup
//
// req_if carries the text one byte per transaction, with last_byte on the final byte.
// A comma, space or period ends a word; last_byte also ends a non-empty final word.
// Each word end yields one transaction on rsp_if: word index and length, palindrome
// and too-long flags, the first longest palindrome so far and a saturating count.
// After the transaction that carries last_byte all counters and records start over.
// A byte inside a word is taken while the controller stays idle. A word end passes
// from idle through the setup, check and finish states to the result being loaded,
// and req_if.ready rises again with rsp_if.valid when the controller is back in idle;
// the check state runs the compare loop, which reads one byte pair per cycle from
// the two read ports of the word buffer ram.
// The result sits in an output register, so bytes inside the next word are accepted
// while it waits; the next word end stalls in its final cycle until rsp_if.ready
// frees the register, and req_if.ready stays low meanwhile.
// reset is synchronous, active high, and returns everything to the start of a text.
module word_palindrome_finder
   import wpf_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input logic        clock,
   input logic        reset,
   wpf_req_if.sink    req_if,
   wpf_rsp_if.source  rsp_if
);

   wpf_cmd_type cmd;
   wpf_sts_type sts;
   logic        ready;

   wpf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_if.valid),
      .req_ready(ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   wpf_datapath #(
      .MAX_WORD(MAX_WORD)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .text_byte       (req_if.text_byte),
      .last_byte       (req_if.last_byte),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .word_number     (rsp_if.word_number),
      .word_length     (rsp_if.word_length),
      .is_palindrome   (rsp_if.is_palindrome),
      .word_too_long   (rsp_if.word_too_long),
      .best_found      (rsp_if.best_found),
      .best_number     (rsp_if.best_number),
      .best_length     (rsp_if.best_length),
      .palindrome_total(rsp_if.palindrome_total)
   );

   assign req_if.ready = ready;

   // a finished word always shows up on the result channel next cycle
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_if.valid)
      else $error("word close did not load the result register");

   // an overlong word is never reported as a palindrome
   a_long_not_pal: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.is_palindrome && rsp_if.word_too_long))
      else $error("overlong word flagged as palindrome");

   // a non-empty palindrome implies a best record exists
   a_best_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_palindrome && rsp_if.word_length != '0)
      |-> rsp_if.best_found)
      else $error("palindrome reported without a best record");

   // no byte is taken while a word is being closed
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.setup || cmd.check || cmd.finish) |-> !req_if.ready)
      else $error("input ready during word close");

endmodule
